[rtl/tone_map_srgb_encode_macros.svh]
// Assertion macros shared by the RTL. Clock clk, reset rst_n (active low).
`ifndef TONE_MAP_SRGB_ENCODE_MACROS_SVH
`define TONE_MAP_SRGB_ENCODE_MACROS_SVH

// Same-cycle implication.
`define TMSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmse: implication check failed");

// Next-cycle implication.
`define TMSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmse: next-cycle check failed");

`endif

[rtl/tmse_pkg.sv]
package tmse_pkg;

  localparam int IW         = 16;   // input channel, signed Q4.12
  localparam int GW         = 14;   // exposure gain, unsigned Q2.12
  localparam int FRAC       = 20;
  localparam int VW         = 25;   // scaled value, Q.20
  localparam int AW         = 34;   // curve linear terms
  localparam int PW         = 60;   // numerator / denominator
  localparam int RW         = 61;   // divider remainder
  localparam int TW         = 21;   // curve result, Q0.20 up to 1.0
  localparam int DIV_STEPS  = 20;
  localparam int ROOT_STEPS = 21;

  localparam logic [TW-1:0] LIN_LIMIT  = 21'd3282;
  localparam logic [GW-1:0] GAIN_RESET = 14'd2458;

  // floor(2^32 / 1000), used for the final divide by 1000
  localparam logic [22:0] RECIP_1000 = 23'd4294967;
  localparam int          RECIP_SH   = 32;

  localparam int CURVE_LAT = 4 + DIV_STEPS;
  localparam int ENC_LAT   = 3 * ROOT_STEPS + 5;
  localparam int LANE_LAT  = CURVE_LAT + ENC_LAT;

  // register index
  localparam logic REG_EXPOSURE_GAIN = 1'b0;

endpackage

[rtl/tmse_curve.sv]
module tmse_curve (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tmse_pkg::GW-1:0]       gain,
  input  logic signed [tmse_pkg::IW-1:0] din,
  output logic [tmse_pkg::TW-1:0]       t_out
);

  localparam int VW = tmse_pkg::VW;
  localparam int AW = tmse_pkg::AW;
  localparam int PW = tmse_pkg::PW;
  localparam int RW = tmse_pkg::RW;
  localparam int NS = tmse_pkg::DIV_STEPS;

  logic [14:0]    x;
  logic [28:0]    prod;
  logic [VW-1:0]  v1_r, v2_r;
  logic [AW-1:0]  a_r, b_r;
  logic [41:0]    na_lo_r, na_hi_r, nb_lo_r, nb_hi_r;
  logic [PW-1:0]  num_r, den_r;

  logic [RW-1:0]  rem_r [NS];
  logic [PW-1:0]  dv_r  [NS];
  logic [NS-1:0]  q_r   [NS];
  logic           sat_r [NS];

  // clamp negatives, apply gain
  assign x    = din[tmse_pkg::IW-1] ? 15'd0 : din[14:0];
  assign prod = 29'(x) * 29'(gain);

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= prod[28:4];
      v2_r    <= v1_r;
      a_r     <= (AW'(v1_r) * AW'(251)) + (AW'(3) << tmse_pkg::FRAC);
      b_r     <= (AW'(v1_r) * AW'(243)) + (AW'(59) << tmse_pkg::FRAC);
      na_lo_r <= 42'(v2_r) * 42'(a_r[16:0]);
      na_hi_r <= 42'(v2_r) * 42'(a_r[33:17]);
      nb_lo_r <= 42'(v2_r) * 42'(b_r[16:0]);
      nb_hi_r <= 42'(v2_r) * 42'(b_r[33:17]);
      num_r   <= PW'(na_lo_r) + (PW'(na_hi_r) << 17);
      den_r   <= PW'(nb_lo_r) + (PW'(nb_hi_r) << 17) + (PW'(14) << 40);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [RW-1:0] rin, sh;
    logic [PW-1:0] dn;
    logic [NS-1:0] qin;
    logic          sin, ge;

    if (k == 0) begin : g_first
      assign rin = RW'(num_r);
      assign dn  = den_r;
      assign qin = '0;
      assign sin = (num_r >= den_r);
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign dn  = dv_r[k-1];
      assign qin = q_r[k-1];
      assign sin = sat_r[k-1];
    end

    assign sh = rin << 1;
    assign ge = (sh >= RW'(dn));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (sh - RW'(dn)) : sh;
        dv_r[k]  <= dn;
        q_r[k]   <= {qin[NS-2:0], ge};
        sat_r[k] <= sin;
      end
    end
  end

  assign t_out = sat_r[NS-1] ? (tmse_pkg::TW'(1) << tmse_pkg::FRAC)
                             : tmse_pkg::TW'(q_r[NS-1]);

endmodule

[rtl/tmse_sqrt.sv]
// floor(sqrt(x * 2^20)) over 21 stages, side band carried along
module tmse_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [20:0] x_in,
  input  logic [41:0] sb_in,
  output logic [20:0] root_out,
  output logic [41:0] sb_out
);

  localparam int NS = tmse_pkg::ROOT_STEPS;

  logic [20:0] r_r  [NS];
  logic [41:0] r2_r [NS];
  logic [40:0] n_r  [NS];
  logic [41:0] sb_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int B = NS - 1 - k;
    logic [20:0] r_i;
    logic [41:0] r2_i, sb_i, c2;
    logic [40:0] n_i;
    logic        ok;

    if (k == 0) begin : g_first
      assign r_i  = '0;
      assign r2_i = '0;
      assign n_i  = {x_in, 20'd0};
      assign sb_i = sb_in;
    end else begin : g_next
      assign r_i  = r_r[k-1];
      assign r2_i = r2_r[k-1];
      assign n_i  = n_r[k-1];
      assign sb_i = sb_r[k-1];
    end

    assign c2 = r2_i + (42'(r_i) << (B + 1)) + (42'd1 << (2 * B));
    assign ok = (c2 <= 42'(n_i));

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= ok ? (r_i | (21'd1 << B)) : r_i;
        r2_r[k] <= ok ? c2 : r2_i;
        n_r[k]  <= n_i;
        sb_r[k] <= sb_i;
      end
    end
  end

  assign root_out = r_r[NS-1];
  assign sb_out   = sb_r[NS-1];

endmodule

[rtl/tmse_encode.sv]
module tmse_encode #(
  parameter int OUT_BITS = 12
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tmse_pkg::TW-1:0]    t_in,
  output logic [OUT_BITS-1:0]        code_out
);

  localparam int NS = tmse_pkg::ROOT_STEPS;
  localparam int YW = OUT_BITS + 12;
  localparam int NW = OUT_BITS + 32;
  localparam int QW = YW + 23;

  localparam logic [NW-1:0] M_N  = NW'((1 << OUT_BITS) - 1);
  localparam logic [NW-1:0] KLIN = NW'(12920) * M_N;
  localparam logic [NW-1:0] KPOW = NW'(1055) * M_N;
  localparam logic [NW-1:0] K55  = (NW'(55) * M_N) << 20;
  localparam logic [NW-1:0] R500 = NW'(500) << 20;
  localparam logic [YW-1:0] M_Y  = YW'((1 << OUT_BITS) - 1);

  // cube root of t * 2^40, digit by digit with running square and cube
  logic [20:0] cb_r  [NS];
  logic [41:0] cb2_r [NS];
  logic [63:0] cb3_r [NS];
  logic [20:0] cbt_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_cube
    localparam int B = NS - 1 - k;
    logic [20:0] r_i, t_i;
    logic [41:0] r2_i;
    logic [63:0] r3_i, c3, n;
    logic        ok;

    if (k == 0) begin : g_first
      assign r_i  = '0;
      assign r2_i = '0;
      assign r3_i = '0;
      assign t_i  = t_in;
    end else begin : g_next
      assign r_i  = cb_r[k-1];
      assign r2_i = cb2_r[k-1];
      assign r3_i = cb3_r[k-1];
      assign t_i  = cbt_r[k-1];
    end

    assign c3 = r3_i + ((64'(r2_i) * 64'd3) << B) + ((64'(r_i) * 64'd3) << (2 * B))
              + (64'd1 << (3 * B));
    assign n  = 64'(t_i) << 40;
    assign ok = (c3 <= n);

    always_ff @(posedge clk) begin
      if (en) begin
        cb_r[k]  <= ok ? (r_i | (21'd1 << B)) : r_i;
        cb2_r[k] <= ok ? (r2_i + (42'(r_i) << (B + 1)) + (42'd1 << (2 * B))) : r2_i;
        cb3_r[k] <= ok ? c3 : r3_i;
        cbt_r[k] <= t_i;
      end
    end
  end

  logic [20:0] q, d;
  logic [41:0] sb1, sb2;

  tmse_sqrt u_sqrt_a (
    .clk      (clk),
    .en       (en),
    .x_in     (cb_r[NS-1]),
    .sb_in    ({cb_r[NS-1], cbt_r[NS-1]}),
    .root_out (q),
    .sb_out   (sb1)
  );

  tmse_sqrt u_sqrt_b (
    .clk      (clk),
    .en       (en),
    .x_in     (q),
    .sb_in    (sb1),
    .root_out (d),
    .sb_out   (sb2)
  );

  logic [20:0]   c_v, t_v;
  logic [41:0]   cd;
  logic [20:0]   s1_r;
  logic [11:0]   t1_r;
  logic          lin1_r, lin2_r;
  logic [NW-1:0] pp_r, numer;
  logic [YW-1:0] y3_r, y4_r, q0, rem, qf;
  logic [QW-1:0] qp_r;
  logic [OUT_BITS-1:0] code_r;

  assign c_v = sb2[41:21];
  assign t_v = sb2[20:0];
  assign cd  = 42'(c_v) * 42'(d);

  assign numer = lin2_r ? pp_r : (pp_r - K55);

  assign q0  = YW'(qp_r >> tmse_pkg::RECIP_SH);
  assign rem = y4_r - YW'(q0 * YW'(1000));
  assign qf  = (rem >= YW'(1000)) ? (q0 + YW'(1)) : q0;

  always_ff @(posedge clk) begin
    if (en) begin
      // t^(5/12) and segment select
      s1_r   <= cd[40:20];
      t1_r   <= t_v[11:0];
      lin1_r <= (t_v <= tmse_pkg::LIN_LIMIT);
      // both segments scaled to a common divide by 1000 * 2^20
      pp_r   <= lin1_r ? (NW'(t1_r) * KLIN + R500) : (NW'(s1_r) * KPOW + R500);
      lin2_r <= lin1_r;
      y3_r   <= (!lin2_r && (pp_r < K55)) ? '0 : YW'(numer >> 20);
      qp_r   <= QW'(y3_r) * QW'(tmse_pkg::RECIP_1000);
      y4_r   <= y3_r;
      code_r <= (qf > M_Y) ? M_Y[OUT_BITS-1:0] : qf[OUT_BITS-1:0];
    end
  end

  assign code_out = code_r;

endmodule

[rtl/tone_map_srgb_encode.sv]
// ACES filmic tone map plus sRGB encode, one RGB pixel per clock while in_ready
// is high. Each pixel goes through three identical channel lanes (gain, curve,
// 20-step restoring divider, 21-step cube root, two 21-step square roots,
// output scaling) and then one output register, and the pipeline takes a new
// pixel every cycle while the skid register is empty. A skid register behind the
// output register lets one more pixel land while a result waits; in_ready
// drops only while that skid register is full. exposure_gain (Q2.12, reset
// 0.6) sits at APB byte address 0 and must only be written while idle.
`include "tone_map_srgb_encode_macros.svh"

module tone_map_srgb_encode #(
  parameter int OUT_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // APB config
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // pixel in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_red_in,
  input  logic signed [15:0]   in_green_in,
  input  logic signed [15:0]   in_blue_in,
  // pixel out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_BITS-1:0]  out_red_out,
  output logic [OUT_BITS-1:0]  out_green_out,
  output logic [OUT_BITS-1:0]  out_blue_out
);

  localparam int LAT = tmse_pkg::LANE_LAT;

  // ---------------- config register ----------------
  logic [tmse_pkg::GW-1:0] gain_r;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready
               && (paddr[2] == tmse_pkg::REG_EXPOSURE_GAIN);
  assign prdata = (paddr[2] == tmse_pkg::REG_EXPOSURE_GAIN) ? 32'(gain_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= tmse_pkg::GAIN_RESET;
    end else if (wr_en) begin
      gain_r <= pwdata[tmse_pkg::GW-1:0];
    end
  end

  // ---------------- lanes ----------------
  // whole pipeline advances while the skid register is empty
  logic           en;
  logic [LAT-1:0] vld_r;
  logic           vld_last;
  logic [tmse_pkg::TW-1:0] t_red, t_grn, t_blu;
  logic [OUT_BITS-1:0]     c_red, c_grn, c_blu;

  tmse_curve u_curve_red (.clk(clk), .en(en), .gain(gain_r), .din(in_red_in),   .t_out(t_red));
  tmse_curve u_curve_grn (.clk(clk), .en(en), .gain(gain_r), .din(in_green_in), .t_out(t_grn));
  tmse_curve u_curve_blu (.clk(clk), .en(en), .gain(gain_r), .din(in_blue_in),  .t_out(t_blu));

  tmse_encode #(.OUT_BITS(OUT_BITS)) u_enc_red (
    .clk(clk), .en(en), .t_in(t_red), .code_out(c_red)
  );
  tmse_encode #(.OUT_BITS(OUT_BITS)) u_enc_grn (
    .clk(clk), .en(en), .t_in(t_grn), .code_out(c_grn)
  );
  tmse_encode #(.OUT_BITS(OUT_BITS)) u_enc_blu (
    .clk(clk), .en(en), .t_in(t_blu), .code_out(c_blu)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign vld_last = vld_r[LAT-1];

  // ---------------- merge: output register + skid ----------------
  logic                out_valid_r, out_valid_nxt;
  logic                skid_v_r, skid_v_nxt;
  logic                out_free;
  logic [OUT_BITS-1:0] out_red_r, out_grn_r, out_blu_r;
  logic [OUT_BITS-1:0] sk_red_r, sk_grn_r, sk_blu_r;

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    if (en) begin
      if (out_free) begin
        out_valid_nxt = vld_last;
      end else begin
        skid_v_nxt = vld_last;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b1;
      skid_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && out_free) begin
      out_red_r <= c_red;
      out_grn_r <= c_grn;
      out_blu_r <= c_blu;
    end else if (!en && out_free) begin
      out_red_r <= sk_red_r;
      out_grn_r <= sk_grn_r;
      out_blu_r <= sk_blu_r;
    end
    if (en && !out_free && vld_last) begin
      sk_red_r <= c_red;
      sk_grn_r <= c_grn;
      sk_blu_r <= c_blu;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_grn_r;
  assign out_blue_out  = out_blu_r;

  // ---------------- checks ----------------
  // skid only fills behind a waiting result
  `TMSE_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_valid_r)
  // a finished pixel arriving at a stalled output is caught by the skid
  `TMSE_ASSERT_NXT(a_skid_catch, en && vld_last && out_valid_r && !out_ready, skid_v_r)
  // skid contents hold while the output stays stalled
  `TMSE_ASSERT_NXT(a_skid_hold, skid_v_r && !out_ready,
    skid_v_r && $stable(sk_red_r) && $stable(sk_grn_r) && $stable(sk_blu_r))

endmodule

[sim/tone_map_srgb_checker.sv]
`timescale 1ns / 1ps

// Predicts each pixel's sRGB codes from the tone curve and compares them
// with the transfers on the output channel.
module tone_map_srgb_checker #(
  parameter int OUT_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [15:0]         in_red_in,
  input  logic [15:0]         in_green_in,
  input  logic [15:0]         in_blue_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [OUT_BITS-1:0] out_red_out,
  input  logic [OUT_BITS-1:0] out_green_out,
  input  logic [OUT_BITS-1:0] out_blue_out,
  output int                  errors,
  output int                  pending
);

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } pixel_code_t;

  localparam longint unsigned ONE_Q20 = 64'd1 << tmse_pkg::FRAC;

  pixel_code_t               srgb_expected[$];
  logic [tmse_pkg::GW-1:0]   gain;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [OUT_BITS-1:0] srgb_code(logic [15:0] raw,
                                                     logic [tmse_pkg::GW-1:0] g);
    longint unsigned m, x, v, num, den, t, rem, c, q, d, s, cand;
    longint          y, numer;
    m = (64'd1 << OUT_BITS) - 1;
    x = raw[15] ? 64'd0 : 64'(raw);
    v = (x * 64'(g)) >> 4;
    num = v * (251 * v + 3 * ONE_Q20);
    den = v * (243 * v + 59 * ONE_Q20) + 14 * ONE_Q20 * ONE_Q20;
    if (num >= den) begin
      t = ONE_Q20;
    end else begin
      rem = num;
      t = 0;
      for (int i = 0; i < tmse_pkg::FRAC; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= den) begin
          rem = rem - den;
          t = t | 64'd1;
        end
      end
    end
    if (t <= 64'(tmse_pkg::LIN_LIMIT)) begin
      y = longint'((1292 * t * m + 50 * ONE_Q20) / (100 * ONE_Q20));
    end else begin
      // t^(5/12) = t^(1/3) * t^(1/12)
      c = 0;
      for (int b = 20; b >= 0; b--) begin
        cand = c | (64'd1 << b);
        if (cand * cand * cand <= (t << 40)) c = cand;
      end
      q = isqrt(c << tmse_pkg::FRAC);
      d = isqrt(q << tmse_pkg::FRAC);
      s = (c * d) >> tmse_pkg::FRAC;
      numer = longint'(1055 * s * m) - longint'(55 * ONE_Q20 * m)
            + longint'(500 * ONE_Q20);
      y = (numer < 0) ? 0 : numer / longint'(1000 * ONE_Q20);
    end
    if (y < 0) y = 0;
    if (y > longint'(m)) y = longint'(m);
    return y[OUT_BITS-1:0];
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    pixel_code_t exp_px;
    if (!rst_n) begin
      gain <= tmse_pkg::GAIN_RESET;
    end else begin
      if (psel && penable && pwrite && pready
          && (paddr >> 2) == 3'(tmse_pkg::REG_EXPOSURE_GAIN))
        gain <= pwdata[tmse_pkg::GW-1:0];
      if (in_valid && in_ready)
        srgb_expected.push_back('{srgb_code(in_red_in, gain),
                                  srgb_code(in_green_in, gain),
                                  srgb_code(in_blue_in, gain)});
      if (out_valid && out_ready) begin
        if (srgb_expected.size() == 0) begin
          report("unexpected transfer", out_red_out, -1);
        end else begin
          exp_px = srgb_expected.pop_front();
          if (out_red_out !== exp_px.red) report("red_out", out_red_out, exp_px.red);
          if (out_green_out !== exp_px.green)
            report("green_out", out_green_out, exp_px.green);
          if (out_blue_out !== exp_px.blue)
            report("blue_out", out_blue_out, exp_px.blue);
        end
      end
    end
    pending = srgb_expected.size();
  end

endmodule

[sim/tb_tone_map_srgb_encode.sv]
`timescale 1ns / 1ps

module tb_tone_map_srgb_encode;

  localparam int OUT_BITS    = 12;
  localparam int DRAIN_WAIT  = tmse_pkg::LANE_LAT + 16;  // pipeline plus skid
  localparam int STALL_LIMIT = 4000;                     // idle cycles before giving up
  localparam int N_PHASE     = 6;
  localparam int PHASE_ITEMS = 215;
  // byte address of the slot after the gain register; writes there are dropped
  localparam logic [2:0] ADDR_GAIN   = 3'(tmse_pkg::REG_EXPOSURE_GAIN) << 2;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [OUT_BITS-1:0] out_red_out, out_green_out, out_blue_out;

  int                  errors, pending;
  int                  quiet_cycles = 0;
  bit                  stalls_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tone_map_srgb_encode #(.OUT_BITS(OUT_BITS)) i_dut (.*);

  tone_map_srgb_checker #(.OUT_BITS(OUT_BITS)) i_checker (.*);

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Sink back-pressure: random stall bursts, always ready once stalls are off.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // write lands on this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One pixel transfer; valid stays up afterwards unless a gap follows.
  task automatic send_pixel(logic signed [15:0] r, logic signed [15:0] g,
                            logic signed [15:0] b);
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Mix of full-range, small (linear segment and knee), mid and negative values.
  function automatic logic signed [15:0] rand_channel();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 63));
      2:       return 16'($urandom_range(0, 8191));
      3:       return 16'($urandom_range(8192, 32767));
      default: return -16'sd1 - 16'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] dir_vals[$];
    dir_vals = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd2, 16'sd3,
                 16'sd5, 16'sd8, 16'sd40, 16'sd300, 16'sd2048, 16'sd4096,
                 16'sd8192, 16'sd16384, 16'sh5555, -16'sd21846};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed at the reset gain: extremes, negatives and the linear segment.
    foreach (dir_vals[i])
      send_pixel(dir_vals[i], dir_vals[(i + 1) % dir_vals.size()],
                 dir_vals[(i + 5) % dir_vals.size()]);
    wait_idle();

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0: apb_write(ADDR_UNUSED, $urandom);           // must be dropped
        1: apb_write(ADDR_GAIN, 32'd0);                // zero gain
        2: apb_write(ADDR_GAIN, 32'd16383);            // max gain
        3: apb_write(ADDR_GAIN, 32'hFFFF_C000 | 32'd4096); // junk above bit 13
        4: apb_write(ADDR_GAIN, $urandom);
        default: apb_write(ADDR_GAIN, 32'($urandom_range(1, 4096)));
      endcase
      if (ph == N_PHASE - 1) stalls_on = 1'b0;
      if (ph == 2) begin
        send_pixel(16'sd32767, -16'sd32768, 16'sd1);
        send_pixel(16'sd0, 16'sd2, 16'sd32767);
      end
      repeat (PHASE_ITEMS) send_pixel(rand_channel(), rand_channel(), rand_channel());
      wait_idle();
    end

    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
